// ----- rtl/core/flash_ring_log_appender_unit_assert.svh -----
// assertion macros for the flash ring log appender
// used by frla_back, no other dependencies
`ifndef FLASH_RING_LOG_APPENDER_UNIT_ASSERT_SVH
`define FLASH_RING_LOG_APPENDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FRLA_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("frla assertion failed");
`define FRLA_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("frla forbidden condition seen");
`else
`define FRLA_ASSERT(lbl, clk_s, rstn_s, prop)
`define FRLA_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

// ----- rtl/core/frla_pkg.sv -----
// shared types, constants and crc-32 helpers of the flash ring log appender
// no dependencies
package frla_pkg;

  localparam int CHANNELS         = 4;
  localparam int MAX_SECTORS      = 256;
  localparam int SLOTS_PER_SECTOR = 126;

  localparam int SECTOR_W   = 8;
  localparam int SLOT_W     = 7;
  localparam int OFFS_W     = 12;
  localparam int ADDR_W     = SECTOR_W + OFFS_W;
  localparam int SEQ_W      = 32;
  localparam int CNT_CFG_W  = 9;

  localparam int HEADER_BYTES = 64;
  localparam int SLOT_BYTES   = 32;

  localparam logic [CNT_CFG_W-1:0] SECTOR_COUNT_RESET = CNT_CFG_W'(256);
  localparam logic [31:0] LOG_MAGIC   = 32'h5345_4354;
  localparam logic [31:0] LOG_VERSION = 32'd1;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;

  localparam logic [63:0] TEMPS_KEEP = (CHANNELS >= 4) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                       ((64'd1 << (16 * CHANNELS)) - 64'd1);

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  localparam int MOD_STEPS = CNT_CFG_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FORMAT = 1'b1;

  localparam logic [1:0] OP_ERASE_SECTOR = 2'd0;
  localparam logic [1:0] OP_ERASE_ALL    = 2'd1;
  localparam logic [1:0] OP_HEADER       = 2'd2;
  localparam logic [1:0] OP_RECORD       = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] sample_time;
    logic [63:0] temps_packed;
  } item_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] flash_addr;
    logic [SEQ_W-1:0]  seq_value;
    logic [31:0]       rec_time;
    logic [63:0]       rec_temps;
    logic [31:0]       crc_value;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    JOB_RECORD,
    JOB_WRAP,
    JOB_FORMAT
  } job_kind_t;

  typedef struct packed {
    job_kind_t           jkind;
    logic [SECTOR_W-1:0] sector;
    logic [SLOT_W-1:0]   slot;
    logic [SEQ_W-1:0]    seq;
    logic [31:0]         rec_time;
    logic [63:0]         temps;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERASE,
    BK_HDR,
    BK_REC0,
    BK_REC1,
    BK_REC2,
    BK_REC3
  } bk_state_t;

  // byte table entry followed by zb zero bytes, reflected crc-32
  function automatic logic [31:0] crc_tab(input int zb, input logic [7:0] x);
    logic [31:0] c;
    c = {24'd0, x};
    for (int i = 0; i < 64; i++) begin
      if (i < 8 * (zb + 1)) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  // eight little-endian bytes per call
  function automatic logic [31:0] crc_step8(input logic [31:0] c, input logic [63:0] w);
    logic [31:0] x;
    logic [31:0] h;
    x = c ^ w[31:0];
    h = w[63:32];
    return crc_tab(7, x[7:0])  ^ crc_tab(6, x[15:8]) ^
           crc_tab(5, x[23:16]) ^ crc_tab(4, x[31:24]) ^
           crc_tab(3, h[7:0])  ^ crc_tab(2, h[15:8]) ^
           crc_tab(1, h[23:16]) ^ crc_tab(0, h[31:24]);
  endfunction

  // four little-endian bytes per call
  function automatic logic [31:0] crc_step4(input logic [31:0] c, input logic [31:0] w);
    logic [31:0] x;
    x = c ^ w;
    return crc_tab(3, x[7:0])  ^ crc_tab(2, x[15:8]) ^
           crc_tab(1, x[23:16]) ^ crc_tab(0, x[31:24]);
  endfunction

endpackage

// ----- rtl/core/frla_front.sv -----
// front end: sector count register, log pointers and request classification
// depends on frla_pkg; feeds jobs into frla_job_fifo
module frla_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  frla_pkg::item_t in_item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [8:0]      cfg_sector_count,
  output logic            jq_push,
  output frla_pkg::job_t  jq_din,
  input  logic            jq_full
);
  import frla_pkg::*;

  logic [CNT_CFG_W-1:0] cfg_r, cfg_nxt;
  logic [SECTOR_W-1:0]  sector_r, sector_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SEQ_W-1:0]     lseq_r, lseq_nxt;
  logic                 busy_r, busy_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_CFG_W-1:0] rem_r, rem_nxt;
  logic [CNT_CFG_W-1:0] num_r, num_nxt;
  logic [31:0]          htime_r, htime_nxt;
  logic [63:0]          htemps_r, htemps_nxt;

  logic                 accept;
  logic [SEQ_W-1:0]     seq_new;
  logic [CNT_CFG_W-1:0] count_eff;
  logic [CNT_CFG_W:0]   trial;
  logic                 fits;

  assign cfg_ready = 1'b1;
  assign full      = busy_r || jq_full;
  assign accept    = push && !full;
  assign seq_new   = lseq_r + SEQ_W'(1);

  always_comb begin
    if (cfg_r == '0) begin
      count_eff = CNT_CFG_W'(1);
    end else if (cfg_r > CNT_CFG_W'(MAX_SECTORS)) begin
      count_eff = CNT_CFG_W'(MAX_SECTORS);
    end else begin
      count_eff = cfg_r;
    end
  end

  // one bit of the restoring sector modulo per cycle
  assign trial = {rem_r, num_r[CNT_CFG_W-1]};
  assign fits  = trial >= {1'b0, count_eff};

  always_comb begin
    cfg_nxt    = cfg_r;
    sector_nxt = sector_r;
    slot_nxt   = slot_r;
    lseq_nxt   = lseq_r;
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    num_nxt    = num_r;
    htime_nxt  = htime_r;
    htemps_nxt = htemps_r;
    jq_push    = 1'b0;
    jq_din     = '0;

    if (cfg_valid && cfg_ready) begin
      cfg_nxt = cfg_sector_count;
    end

    if (accept) begin
      if (in_item.kind == KIND_FORMAT) begin
        jq_push       = 1'b1;
        jq_din.jkind  = JOB_FORMAT;
        sector_nxt    = '0;
        slot_nxt      = '0;
        lseq_nxt      = '0;
      end else if (slot_r >= SLOT_W'(SLOTS_PER_SECTOR)) begin
        busy_nxt   = 1'b1;
        cnt_nxt    = MOD_CNT_W'(MOD_STEPS);
        rem_nxt    = '0;
        num_nxt    = CNT_CFG_W'(sector_r) + CNT_CFG_W'(1);
        htime_nxt  = in_item.sample_time;
        htemps_nxt = in_item.temps_packed & TEMPS_KEEP;
        lseq_nxt   = seq_new;
        slot_nxt   = SLOT_W'(1);
      end else begin
        jq_push         = 1'b1;
        jq_din.jkind    = JOB_RECORD;
        jq_din.sector   = sector_r;
        jq_din.slot     = slot_r;
        jq_din.seq      = seq_new;
        jq_din.rec_time = in_item.sample_time;
        jq_din.temps    = in_item.temps_packed & TEMPS_KEEP;
        lseq_nxt        = seq_new;
        slot_nxt        = slot_r + SLOT_W'(1);
      end
    end

    if (busy_r) begin
      if (cnt_r != '0) begin
        rem_nxt = fits ? CNT_CFG_W'(trial - {1'b0, count_eff}) : trial[CNT_CFG_W-1:0];
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - MOD_CNT_W'(1);
      end else if (!jq_full) begin
        jq_push         = 1'b1;
        jq_din.jkind    = JOB_WRAP;
        jq_din.sector   = rem_r[SECTOR_W-1:0];
        jq_din.slot     = '0;
        jq_din.seq      = lseq_r;
        jq_din.rec_time = htime_r;
        jq_din.temps    = htemps_r;
        sector_nxt      = rem_r[SECTOR_W-1:0];
        busy_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= SECTOR_COUNT_RESET;
      sector_r <= '0;
      slot_r   <= '0;
      lseq_r   <= '0;
      busy_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cfg_r    <= cfg_nxt;
      sector_r <= sector_nxt;
      slot_r   <= slot_nxt;
      lseq_r   <= lseq_nxt;
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    num_r    <= num_nxt;
    htime_r  <= htime_nxt;
    htemps_r <= htemps_nxt;
  end

endmodule

// ----- rtl/core/frla_job_fifo.sv -----
// short job queue between the front end and the command engine
// depends on frla_pkg
module frla_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  frla_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output frla_pkg::job_t dout,
  output logic           empty
);
  import frla_pkg::*;

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r;
  logic [JOB_PTR_W-1:0] rd_ptr_r;
  logic [JOB_CNT_W-1:0] cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = cnt_r == JOB_CNT_W'(JOB_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + JOB_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + JOB_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + JOB_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - JOB_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/frla_back.sv -----
// command engine: expands jobs into flash commands, runs the crc-32 passes
// depends on frla_pkg and flash_ring_log_appender_unit_assert.svh
`include "flash_ring_log_appender_unit_assert.svh"
module frla_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              jq_empty,
  input  frla_pkg::job_t    jq_dout,
  output logic              jq_pop,
  output logic              empty,
  input  logic              pop,
  output frla_pkg::result_t out_result
);
  import frla_pkg::*;

  bk_state_t        state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [31:0]      crc_r, crc_nxt;
  result_t          out_r;
  logic             out_vld_r;
  result_t          res;
  logic             emit;
  logic             free;
  logic             room;
  logic             is_fmt;
  logic [SEQ_W-1:0] hseq;
  logic [OFFS_W-1:0] rec_offs;

  assign room       = !out_vld_r || pop;
  assign empty      = !out_vld_r;
  assign out_result = out_r;
  assign is_fmt     = job_r.jkind == JOB_FORMAT;
  assign hseq       = is_fmt ? SEQ_W'(1) : job_r.seq;
  assign rec_offs   = OFFS_W'(job_r.slot) * OFFS_W'(SLOT_BYTES) + OFFS_W'(HEADER_BYTES);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    crc_nxt   = crc_r;
    emit      = 1'b0;
    free      = 1'b0;
    jq_pop    = 1'b0;
    res       = '0;

    unique case (state_r)
      BK_IDLE: begin
        free = 1'b1;
      end
      BK_ERASE: begin
        res.op         = is_fmt ? OP_ERASE_ALL : OP_ERASE_SECTOR;
        res.flash_addr = is_fmt ? '0 : {job_r.sector, OFFS_W'(0)};
        if (room) begin
          emit      = 1'b1;
          state_nxt = BK_HDR;
        end
      end
      BK_HDR: begin
        res.op         = OP_HEADER;
        res.flash_addr = {job_r.sector, OFFS_W'(0)};
        res.seq_value  = hseq;
        res.crc_value  = crc_step8(CRC_ONES, {hseq, LOG_VERSION}) ^ CRC_ONES;
        res.last       = is_fmt;
        if (room) begin
          emit = 1'b1;
          if (is_fmt) begin
            state_nxt = BK_IDLE;
            free      = 1'b1;
          end else begin
            state_nxt = BK_REC0;
          end
        end
      end
      BK_REC0: begin
        crc_nxt   = crc_step8(CRC_ONES, {job_r.rec_time, job_r.seq});
        state_nxt = BK_REC1;
      end
      BK_REC1: begin
        crc_nxt   = crc_step8(crc_r, job_r.temps | ~TEMPS_KEEP);
        state_nxt = BK_REC2;
      end
      BK_REC2: begin
        crc_nxt   = crc_step8(crc_r, {CRC_ONES, CRC_ONES});
        state_nxt = BK_REC3;
      end
      BK_REC3: begin
        res.op         = OP_RECORD;
        res.flash_addr = {job_r.sector, rec_offs};
        res.seq_value  = job_r.seq;
        res.rec_time   = job_r.rec_time;
        res.rec_temps  = job_r.temps;
        res.crc_value  = crc_step4(crc_r, CRC_ONES) ^ CRC_ONES;
        res.last       = 1'b1;
        if (room) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
          free      = 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // take the next job as soon as the current one is done
    if (free && !jq_empty) begin
      jq_pop    = 1'b1;
      job_nxt   = jq_dout;
      state_nxt = (jq_dout.jkind == JOB_RECORD) ? BK_REC0 : BK_ERASE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    crc_r <= crc_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  `FRLA_ASSERT(a_rec_pass, clk, rst_n, state_r == BK_REC0 |=> state_r == BK_REC1 ##1 state_r == BK_REC2 ##1 state_r == BK_REC3)
  `FRLA_ASSERT(a_pop_when_free, clk, rst_n, jq_pop |-> (state_r == BK_IDLE || (emit && res.last)))
  `FRLA_ASSERT(a_rec_last, clk, rst_n, (emit && res.op == OP_RECORD) |-> res.last)
  `FRLA_NEVER(a_emit_full, clk, rst_n, emit && out_vld_r && !pop)

endmodule

// ----- rtl/core/flash_ring_log_appender_unit.sv -----
// top level of the flash ring log appender
// depends on frla_pkg, frla_front, frla_job_fifo and frla_back
//
// Usage: requests enter through push/full with in_item (kind, sample_time,
// temps_packed); a request is taken on a clock edge with push high and full low.
// Flash commands leave through empty/pop with out_result, oldest first; the
// one shown while empty is low is taken on an edge with pop high.
// cfg_valid/cfg_ready/cfg_sector_count write the sector count (ready always
// high); write it only while no request is in flight.
// An append causes one record write, an append into a full sector causes
// erase sector, header and record, a format causes erase all and header.
// A record command passes the job queue, the states BK_REC0 to BK_REC3
// and the output register, an erase the job queue, BK_ERASE and the output
// register. The crc engine covers a record in three 8-byte steps and one
// 4-byte step; plain appends follow back to back while the output register
// is free. A sector change holds full high in the front end for the 9 steps
// of the bit-serial sector modulo and until the job is queued.
// A two-entry job queue parts front and back; the output register holds a
// command while pop is low and the engine waits without losing anything.
// Reset (synchronous, rst_n low) clears pointers and sequence, empties the
// queues and sets the sector count to 256.
module flash_ring_log_appender_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  frla_pkg::item_t   in_item,
  output logic              empty,
  input  logic              pop,
  output frla_pkg::result_t out_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_sector_count
);
  import frla_pkg::*;

  logic jq_push;
  logic jq_full;
  logic jq_pop;
  logic jq_empty;
  job_t jq_din;
  job_t jq_dout;

  frla_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_item          (in_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_sector_count (cfg_sector_count),
    .jq_push          (jq_push),
    .jq_din           (jq_din),
    .jq_full          (jq_full)
  );

  frla_job_fifo u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .din   (jq_din),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .empty (jq_empty)
  );

  frla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .jq_empty   (jq_empty),
    .jq_dout    (jq_dout),
    .jq_pop     (jq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_result (out_result)
  );

endmodule
